// ===== rtl/terminal_cell_color_resolver_top_assert.svh =====
// Assertion macros for the cell colour resolver.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef TERMINAL_CELL_COLOR_RESOLVER_TOP_ASSERT_SVH
`define TERMINAL_CELL_COLOR_RESOLVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked outside reset
`define TCCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked in every cycle, reset included
`define TCCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TCCR_ASSERT(lbl, prop, msg)
`define TCCR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/tccr_pkg.sv =====
// Shared types, register indexes and the 256-entry palette of the cell colour resolver.
// No dependencies.
package tccr_pkg;

  localparam int unsigned RgbW    = 24;
  localparam int unsigned CfgIdxW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEF_FORE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEF_BACK = 8'd1;

  localparam logic [RgbW-1:0] DEF_FORE_RESET = 24'h202428;
  localparam logic [RgbW-1:0] DEF_BACK_RESET = 24'hffffff;

  typedef struct packed {
    logic [7:0] glyph_code;
    logic [7:0] fore_index;
    logic [7:0] back_index;
    logic       fore_is_default;
    logic       back_is_default;
    logic       bold_flag;
    logic       reverse_flag;
    logic       dim_flag;
    logic       underline_flag;
  } cell_in_t;

  typedef struct packed {
    logic [7:0]      glyph_out;
    logic [RgbW-1:0] fore_rgb;
    logic [RgbW-1:0] back_rgb;
    logic            needs_fill;
    logic            underline_out;
  } cell_out_t;

  // Word held between the colour lookup and the dim blend
  typedef struct packed {
    logic [7:0]      glyph;
    logic [RgbW-1:0] fg;
    logic [RgbW-1:0] bg;
    logic            fill;
    logic            dim;
    logic            ul;
  } mid_t;

  typedef logic [RgbW-1:0] palette_t [256];

  localparam logic [RgbW-1:0] BASE_COLORS [16] = '{
    24'h000000, 24'hcc0000, 24'h4e9a06, 24'hc4a000,
    24'h3465a4, 24'h75507b, 24'h06989a, 24'h999999,
    24'h555753, 24'hef2929, 24'h73d216, 24'hedd400,
    24'h729fcf, 24'had7fa8, 24'h2cc7c7, 24'hb0b0b0
  };

  // Cube channel level: 0 for step 0, else 55 + 40 per step
  function automatic int unsigned cube_level(input int unsigned n);
    return (n == 0) ? 0 : 55 + 40 * n;
  endfunction

  // Base colours, 6x6x6 cube, then the grey ramp
  function automatic palette_t build_palette();
    palette_t    p;
    int unsigned v;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned y;
    for (int unsigned i = 0; i < 256; i++) begin
      if (i < 16) begin
        p[i] = BASE_COLORS[i];
      end else if (i < 232) begin
        v    = i - 16;
        r    = cube_level(v / 36);
        g    = cube_level((v / 6) % 6);
        b    = cube_level(v % 6);
        p[i] = {r[7:0], g[7:0], b[7:0]};
      end else begin
        y    = 8 + (i - 232) * 10;
        p[i] = {y[7:0], y[7:0], y[7:0]};
      end
    end
    return p;
  endfunction

  localparam palette_t PALETTE = build_palette();

endpackage

// ===== rtl/tccr_dim_blend.sv =====
// Dim blend: each channel becomes (bg*127 + fg*128 + 127) / 255.
// Depends on tccr_pkg.
module tccr_dim_blend (
  input  logic [tccr_pkg::RgbW-1:0] bg_i,
  input  logic [tccr_pkg::RgbW-1:0] fg_i,
  input  logic                      dim_i,
  output logic [tccr_pkg::RgbW-1:0] fg_o
);
  import tccr_pkg::*;

  logic [RgbW-1:0] blend;

  // Three independent channels; /255 as (x + (x >> 8) + 1) >> 8, exact for sums up to 65152
  always_comb begin
    logic [15:0] sum;
    logic [15:0] quo;
    blend = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = ({8'd0, bg_i[ch*8 +: 8]} * 16'd127) + {1'b0, fg_i[ch*8 +: 8], 7'd0} + 16'd127;
      quo = sum + {8'd0, sum[15:8]} + 16'd1;
      blend[ch*8 +: 8] = quo[15:8];
    end
  end

  assign fg_o = dim_i ? blend : fg_i;

endmodule

// ===== rtl/terminal_cell_color_resolver_top.sv =====
// Cell colour resolver top level: lookup stage, blend stage, output register.
// Depends on tccr_pkg, tccr_dim_blend and terminal_cell_color_resolver_top_assert.svh.
//
// Takes one text cell per clock while the output is not stalled and returns
// its glyph and final RGB colours. Each cell passes two registers, the
// first stage doing the palette lookup, bold promotion, default selection
// and reverse swap, the second the dim blend into the output register.
// Each stage holds its word while the stage after it is full, so input is
// taken whenever the first stage is empty or moving on.
// Default colours are written through the configuration port (index 0
// foreground, 1 background, other indexes ignored) and take effect for cells
// accepted afterwards; the port is always ready.
`include "terminal_cell_color_resolver_top_assert.svh"

module terminal_cell_color_resolver_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tccr_pkg::cell_in_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tccr_pkg::cell_out_t          out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tccr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tccr_pkg::RgbW-1:0]    cfg_data_i
);
  import tccr_pkg::*;

  logic [RgbW-1:0] def_fore_q, def_back_q;
  logic            s1_valid_q, s1_valid_d;
  mid_t            s1_q, s1_d;
  logic            out_valid_q, out_valid_d;
  cell_out_t       out_q, out_d;
  logic            in_fire, s2_ready, s2_load;
  logic [7:0]      fidx;
  logic [RgbW-1:0] fg_lk, bg_lk, fg_dim;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_fore_q <= DEF_FORE_RESET;
      def_back_q <= DEF_BACK_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEF_FORE: def_fore_q <= cfg_data_i;
        CFG_DEF_BACK: def_back_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake between stages
  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s2_load    = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  // Stage 1: bold promotion, palette lookup, defaults, reverse
  always_comb begin
    fidx = in_word_i.fore_index;
    if (in_word_i.bold_flag && !in_word_i.fore_is_default && fidx[7:3] == 5'd0) begin
      fidx[3] = 1'b1;
    end
    fg_lk = in_word_i.fore_is_default ? def_fore_q : PALETTE[fidx];
    bg_lk = in_word_i.back_is_default ? def_back_q : PALETTE[in_word_i.back_index];

    s1_d.glyph = in_word_i.glyph_code;
    s1_d.dim   = in_word_i.dim_flag;
    s1_d.ul    = in_word_i.underline_flag;
    if (in_word_i.reverse_flag) begin
      s1_d.fg   = bg_lk;
      s1_d.bg   = fg_lk;
      s1_d.fill = 1'b1;
    end else begin
      s1_d.fg   = fg_lk;
      s1_d.bg   = bg_lk;
      s1_d.fill = !in_word_i.back_is_default;
    end
  end

  assign s1_valid_d = in_fire ? 1'b1 : (s2_load ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: dim blend into the output register
  tccr_dim_blend u_blend (
    .bg_i  (s1_q.bg),
    .fg_i  (s1_q.fg),
    .dim_i (s1_q.dim),
    .fg_o  (fg_dim)
  );

  always_comb begin
    out_d.glyph_out     = s1_q.glyph;
    out_d.fore_rgb      = fg_dim;
    out_d.back_rgb      = s1_q.bg;
    out_d.needs_fill    = s1_q.fill;
    out_d.underline_out = s1_q.ul;
  end

  assign out_valid_d = s2_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  `TCCR_ASSERT(a_full_blocks_input, (out_valid_o && !out_ready_i && s1_valid_q) |-> !in_ready_o, "input taken while both stages are full")
  `TCCR_ASSERT(a_result_from_stage1, $rose(out_valid_o) |-> $past(s1_valid_q), "result appeared without a first-stage word")
  `TCCR_ASSERT(a_no_dim_passes_fore, (s2_load && !s1_q.dim) |=> (out_word_o.fore_rgb == $past(s1_q.fg)), "foreground changed without dim")
  `TCCR_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "configuration port not ready")

endmodule

// ===== tb/terminal_cell_color_resolver_top_test.sv =====
// Testbench for terminal_cell_color_resolver_top: random and directed cells with bursty
// input, a stalling receiver and a scoreboard that predicts each result word.
// Depends on tccr_pkg and the resolver RTL.
module terminal_cell_color_resolver_top_test;
  import tccr_pkg::*;

  localparam int unsigned LIMIT          = 200000;
  localparam int unsigned CELLS_PER_PASS = 108;

  // Attribute flag bits of a cell, in payload order
  localparam logic [5:0] F_FDEF = 6'b100000;
  localparam logic [5:0] F_BDEF = 6'b010000;
  localparam logic [5:0] F_BOLD = 6'b001000;
  localparam logic [5:0] F_REV  = 6'b000100;
  localparam logic [5:0] F_DIM  = 6'b000010;
  localparam logic [5:0] F_UL   = 6'b000001;

  // Predicts the resolved colours of each accepted cell and checks result words in order
  class resolved_cell_checker;
    cell_out_t       resolved_q[$];
    logic [RgbW-1:0] def_fore;
    logic [RgbW-1:0] def_back;
    int unsigned     errors;
    int unsigned     words_seen;

    function new();
      def_fore   = DEF_FORE_RESET;
      def_back   = DEF_BACK_RESET;
      errors     = 0;
      words_seen = 0;
    endfunction

    task report(input string what);
      $display("mismatch at word %0d: %s", words_seen, what);
      errors++;
    endtask

    function void set_register(input logic [CfgIdxW-1:0] idx, input logic [RgbW-1:0] data);
      if (idx == CFG_DEF_FORE) begin
        def_fore = data;
      end else if (idx == CFG_DEF_BACK) begin
        def_back = data;
      end
    endfunction

    function int unsigned cube_step(input int unsigned n);
      return (n == 0) ? 0 : 55 + 40 * n;
    endfunction

    // 256-colour map: sixteen base colours, then the xterm 6x6x6 cube and grey ramp
    function logic [RgbW-1:0] palette_rgb(input logic [7:0] idx);
      int unsigned v;
      int unsigned y;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      if (idx < 16) begin
        case (idx[3:0])
          4'h0: return 24'h000000;  4'h1: return 24'hcc0000;
          4'h2: return 24'h4e9a06;  4'h3: return 24'hc4a000;
          4'h4: return 24'h3465a4;  4'h5: return 24'h75507b;
          4'h6: return 24'h06989a;  4'h7: return 24'h999999;
          4'h8: return 24'h555753;  4'h9: return 24'hef2929;
          4'ha: return 24'h73d216;  4'hb: return 24'hedd400;
          4'hc: return 24'h729fcf;  4'hd: return 24'had7fa8;
          4'he: return 24'h2cc7c7;  4'hf: return 24'hb0b0b0;
        endcase
      end
      if (idx < 232) begin
        v = idx - 16;
        r = 8'(cube_step(v / 36));
        g = 8'(cube_step((v / 6) % 6));
        b = 8'(cube_step(v % 6));
        return {r, g, b};
      end
      y = 8 + (idx - 232) * 10;
      return {y[7:0], y[7:0], y[7:0]};
    endfunction

    // Per channel (bg*127 + fg*128 + 127) / 255
    function logic [RgbW-1:0] dim_toward(input logic [RgbW-1:0] bg, input logic [RgbW-1:0] fg);
      logic [RgbW-1:0] mix;
      int unsigned     s;
      for (int ch = 0; ch < 3; ch++) begin
        s = (int'(bg[8*ch +: 8]) * 127 + int'(fg[8*ch +: 8]) * 128 + 127) / 255;
        mix[8*ch +: 8] = s[7:0];
      end
      return mix;
    endfunction

    function cell_out_t resolve_cell(input cell_in_t c);
      cell_out_t       r;
      logic [7:0]      fi;
      logic [RgbW-1:0] fg;
      logic [RgbW-1:0] bg;
      logic [RgbW-1:0] t;
      fi = c.fore_index;
      // bold lifts the eight dark base colours to their bright twins
      if (c.bold_flag && !c.fore_is_default && fi < 8) fi = fi + 8'd8;
      fg = c.fore_is_default ? def_fore : palette_rgb(fi);
      bg = c.back_is_default ? def_back : palette_rgb(c.back_index);
      r.needs_fill = !c.back_is_default;
      if (c.reverse_flag) begin
        t  = fg;
        fg = bg;
        bg = t;
        r.needs_fill = 1'b1;
      end
      if (c.dim_flag) fg = dim_toward(bg, fg);
      r.glyph_out     = c.glyph_code;
      r.fore_rgb      = fg;
      r.back_rgb      = bg;
      r.underline_out = c.underline_flag;
      return r;
    endfunction

    task note_cell(input cell_in_t c);
      resolved_q.push_back(resolve_cell(c));
    endtask

    task compare(input string name, input logic [RgbW-1:0] got, input logic [RgbW-1:0] want);
      if (got !== want) report($sformatf("%s got %h, predicted %h", name, got, want));
    endtask

    task check_word(input cell_out_t got);
      cell_out_t want;
      words_seen++;
      if (resolved_q.size() == 0) begin
        report("result word with no cell outstanding");
        return;
      end
      want = resolved_q.pop_front();
      compare("glyph_out", 24'(got.glyph_out), 24'(want.glyph_out));
      compare("fore_rgb", got.fore_rgb, want.fore_rgb);
      compare("back_rgb", got.back_rgb, want.back_rgb);
      compare("needs_fill", 24'(got.needs_fill), 24'(want.needs_fill));
      compare("underline_out", 24'(got.underline_out), 24'(want.underline_out));
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  cell_in_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  cell_out_t           out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [RgbW-1:0]     cfg_data_i  = '0;

  resolved_cell_checker sb;
  int unsigned          cycles     = 0;
  int unsigned          cells_sent = 0;
  int unsigned          burst_left = 0;
  int unsigned          stall_mode = 0;
  int unsigned          mode_left  = 0;
  int unsigned          stall_left = 0;

  terminal_cell_color_resolver_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: stall behaviour switches between four randomly chosen modes
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 12);
        end
        default: out_ready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Observe handshakes on all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_cell(in_word_i);
      if (out_valid_o && out_ready_i) sb.check_word(out_word_o);
    end
  end

  function automatic cell_in_t make_cell(input logic [7:0] g, input logic [7:0] f,
                                         input logic [7:0] b, input logic [5:0] flags);
    return {g, f, b, flags};
  endfunction

  // Indices near the palette region boundaries turn up often
  function automatic logic [7:0] pick_index();
    logic [7:0] corner_idx [8] = '{8'd0, 8'd7, 8'd8, 8'd15, 8'd16, 8'd231, 8'd232, 8'd255};
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 15));
      1: return corner_idx[3'($urandom_range(0, 7))];
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic cell_in_t random_cell();
    return make_cell(8'($urandom), pick_index(), pick_index(), 6'($urandom_range(0, 63)));
  endfunction

  // Sender: bursts of random length, random gaps between them
  task automatic send_cell(input cell_in_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    cells_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RgbW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Wait for every outstanding word, then let the two-stage pipe settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.words_seen < cells_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_directed();
    send_cell(make_cell(8'h00, 8'd0, 8'd0, 6'b000000));
    send_cell(make_cell(8'hff, 8'd255, 8'd255, F_UL));
    // bold promotion of the dark base colours
    send_cell(make_cell(8'h41, 8'd7, 8'd0, F_BOLD));
    send_cell(make_cell(8'h42, 8'd0, 8'd16, F_BOLD));
    // bold leaves indices of eight and above alone
    send_cell(make_cell(8'h43, 8'd8, 8'd231, F_BOLD));
    // bold with the default foreground: no promotion
    send_cell(make_cell(8'h44, 8'd3, 8'd232, F_BOLD | F_FDEF));
    send_cell(make_cell(8'h45, 8'd15, 8'd16, 6'b000000));
    // indices are ignored when both defaults are set
    send_cell(make_cell(8'h46, 8'd3, 8'd9, F_FDEF | F_BDEF));
    send_cell(make_cell(8'h47, 8'd1, 8'd4, F_REV));
    // reverse forces a fill even on the default background
    send_cell(make_cell(8'h48, 8'd2, 8'd5, F_REV | F_BDEF));
    send_cell(make_cell(8'h49, 8'd9, 8'd0, F_DIM));
    // dim blends after the swap
    send_cell(make_cell(8'h4a, 8'd196, 8'd21, F_DIM | F_REV));
    send_cell(make_cell(8'h4b, 8'd255, 8'd232, F_DIM | F_FDEF | F_BDEF));
    send_cell(make_cell(8'hff, 8'd5, 8'd250, 6'b111111));
    send_cell(make_cell(8'h4c, 8'd6, 8'd6, F_BOLD | F_REV | F_DIM));
    send_cell(make_cell(8'h4d, 8'd0, 8'd0, F_BDEF));
    send_cell(make_cell(8'h4e, 8'd231, 8'd255, F_DIM));
    send_cell(make_cell(8'h80, 8'd16, 8'd16, F_DIM | F_UL));
    send_cell(make_cell(8'h7f, 8'd232, 8'd15, F_REV | F_FDEF | F_UL));
  endtask

  // Stimulus: six passes, default colours rewritten between them
  initial begin
    logic [RgbW-1:0] shade;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        wait_idle();
        case (p)
          1: begin
            write_reg(CFG_DEF_FORE, 24'h000000);
            write_reg(CFG_DEF_BACK, 24'hffffff);
          end
          2: begin
            write_reg(CFG_DEF_FORE, 24'hffffff);
            write_reg(CFG_DEF_BACK, 24'h000000);
          end
          3: begin
            write_reg(CFG_DEF_FORE, 24'($urandom));
            // unused indexes must leave both registers alone
            write_reg(CfgIdxW'($urandom_range(CFG_DEF_BACK + 1, 255)), 24'($urandom));
            write_reg(CFG_DEF_BACK, 24'($urandom));
          end
          4: begin
            shade = 24'($urandom);
            write_reg(CFG_DEF_FORE, shade);
            write_reg(CFG_DEF_BACK, shade);
          end
          default: begin
            write_reg(CFG_DEF_BACK, 24'($urandom));
            write_reg(CFG_DEF_FORE, 24'($urandom));
            write_reg({CfgIdxW{1'b1}}, 24'($urandom));
          end
        endcase
        cfg_valid_i <= 1'b0;
      end
      if (p < 2) send_directed();
      repeat (CELLS_PER_PASS) send_cell(random_cell());
    end
    wait_idle();
    if (sb.resolved_q.size() != 0) begin
      sb.report($sformatf("%0d predicted words never arrived", sb.resolved_q.size()));
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
